/* hdl/u8d_pkg.sv */
// ----------------------------------------------------------------------------
// u8d_pkg
// shared types and constants for the streaming utf-8 decoder
// ----------------------------------------------------------------------------
package u8d_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned CpWidth   = 21;

   // lead byte class masks and patterns
   localparam logic [ByteWidth-1:0] MaskTop1  = 8'b1000_0000;
   localparam logic [ByteWidth-1:0] MaskTop3  = 8'b1110_0000;
   localparam logic [ByteWidth-1:0] Lead2Pat  = 8'b1100_0000;
   localparam logic [ByteWidth-1:0] MaskTop4  = 8'b1111_0000;
   localparam logic [ByteWidth-1:0] MaskTop5  = 8'b1111_1000;
   localparam logic [ByteWidth-1:0] Lead3Pat  = MaskTop3;
   localparam logic [ByteWidth-1:0] Lead4Pat  = MaskTop4;

   // payload masks
   localparam logic [ByteWidth-1:0] ContMask  = 8'b0011_1111;
   localparam logic [ByteWidth-1:0] Lead2Mask = 8'b0001_1111;
   localparam logic [ByteWidth-1:0] Lead3Mask = 8'b0000_1111;
   localparam logic [ByteWidth-1:0] Lead4Mask = 8'b0000_0111;

   typedef enum logic [1:0] {
      STATUS_CHAR    = 2'd0,
      STATUS_NUL     = 2'd1,
      STATUS_INVALID = 2'd2,
      STATUS_TRUNC   = 2'd3
   } status_type;

   // continuation bytes still expected
   typedef enum logic [1:0] {
      REMAIN_NONE  = 2'd0,
      REMAIN_ONE   = 2'd1,
      REMAIN_TWO   = 2'd2,
      REMAIN_THREE = 2'd3
   } remain_type;

   typedef struct packed {
      logic [ByteWidth-1:0] in_byte;
      logic                 end_of_string;
   } req_word_type;

   typedef struct packed {
      logic [CpWidth-1:0] code_point;
      status_type         status;
      logic               last;
   } rsp_word_type;

   // decoder step result, handed to the output stage
   typedef struct packed {
      logic         has_result;
      rsp_word_type word;
   } step_type;

endpackage

/* hdl/u8d_req_if.sv */
// ----------------------------------------------------------------------------
// u8d_req_if
// byte channel into the decoder: valid/ready with one byte and end flag
// ----------------------------------------------------------------------------
interface u8d_req_if;
   logic                          valid;
   logic                          ready;
   logic [u8d_pkg::ByteWidth-1:0] in_byte;
   logic                          end_of_string;

   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

/* hdl/u8d_rsp_if.sv */
// ----------------------------------------------------------------------------
// u8d_rsp_if
// result channel out of the decoder: valid/ready with code point and status
// ----------------------------------------------------------------------------
interface u8d_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [u8d_pkg::CpWidth-1:0] code_point;
   logic [1:0]                  status;
   logic                        last;

   modport source (output valid, output code_point, output status, output last,
                   input ready);
   modport sink   (input valid, input code_point, input status, input last,
                   output ready);
endinterface

/* hdl/utf8_stream_decoder_core.sv */
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core
// streaming utf-8 decoder, one byte word in, at most one code point word out
// ----------------------------------------------------------------------------
// usage
//   req_bus carries one byte of a utf-8 string per word plus end_of_string,
//   which marks the last byte. rsp_bus returns code_point, status and last.
//   a multi-byte sequence gives one word when its final byte arrives; a NUL
//   lead byte, an invalid lead byte or a sequence cut off by the end flag
//   gives a stop word (code_point zero, last set). after a stop, bytes are
//   dropped until the end flag, which clears the decoder for the next string.
// path and throughput
//   an accepted byte is held in the input register, is decoded in a single
//   combinational step and lands in the result register, where rsp valid
//   rises. one byte per cycle sustained while the result register is free,
//   set by the single pass through the decode step and its state registers.
// reset
//   synchronous, active high; empties both registers and clears the sequence
//   count, accumulator and stop flag.
// stall
//   when rsp ready is low the result register holds; a byte that would give a
//   result waits in the input register, and req ready drops once it is full.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core (
   input  logic           clock,
   input  logic           reset,
   u8d_req_if.sink        req_bus,
   u8d_rsp_if.source      rsp_bus
);

   // input side
   u8d_pkg::req_word_type req_word;
   u8d_pkg::req_word_type dec_word;
   logic                  dec_valid;
   logic                  dec_take;

   // decode and output side
   u8d_pkg::step_type     step;
   logic                  out_free;
   u8d_pkg::rsp_word_type rsp_word;

   assign req_word.in_byte       = req_bus.in_byte;
   assign req_word.end_of_string = req_bus.end_of_string;

   // byte register, refilled in the same cycle the decoder takes its word
   u8d_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_bus.valid),
      .up_ready (req_bus.ready),
      .up_word  (req_word),
      .dn_valid (dec_valid),
      .dn_take  (dec_take),
      .dn_word  (dec_word)
   );

   // one decode step per byte, state moves only when the byte is taken
   u8d_decoder u_decoder (
      .clock      (clock),
      .reset      (reset),
      .word_valid (dec_valid),
      .word       (dec_word),
      .out_free   (out_free),
      .take       (dec_take),
      .step       (step)
   );

   // result register, loaded only for bytes that produce a word
   u8d_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (dec_take && step.has_result),
      .load_word (step.word),
      .free      (out_free),
      .dn_valid  (rsp_bus.valid),
      .dn_ready  (rsp_bus.ready),
      .dn_word   (rsp_word)
   );

   assign rsp_bus.code_point = rsp_word.code_point;
   assign rsp_bus.status     = rsp_word.status;
   assign rsp_bus.last       = rsp_word.last;

endmodule

/* hdl/u8d_in_stage.sv */
// ----------------------------------------------------------------------------
// u8d_in_stage
// input register: holds one byte word until the decoder takes it
// ----------------------------------------------------------------------------
module u8d_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  u8d_pkg::req_word_type up_word,
   output logic                  dn_valid,
   input  logic                  dn_take,
   output u8d_pkg::req_word_type dn_word
);

   logic                  valid_ff, valid_in;
   u8d_pkg::req_word_type word_ff, word_in;

   assign up_ready = !valid_ff || dn_take;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (up_ready) begin
         valid_in = up_valid;
         word_in  = up_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign dn_valid = valid_ff;
   assign dn_word  = word_ff;

endmodule

/* hdl/u8d_decoder.sv */
// ----------------------------------------------------------------------------
// u8d_decoder
// per-byte decode step with sequence state (count, accumulator, stop flag)
// ----------------------------------------------------------------------------
module u8d_decoder (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  word_valid,
   input  u8d_pkg::req_word_type word,
   input  logic                  out_free,
   output logic                  take,
   output u8d_pkg::step_type     step
);

   u8d_pkg::remain_type           remain_ff, remain_in;
   logic [u8d_pkg::CpWidth-1:0]   acc_ff, acc_in;
   logic                          stopped_ff, stopped_in;
   logic [u8d_pkg::CpWidth-1:0]   shifted;
   logic [u8d_pkg::ByteWidth-1:0] b;
   logic                          eos;

   assign b       = word.in_byte;
   assign eos     = word.end_of_string;
   assign shifted = {acc_ff[u8d_pkg::CpWidth-7:0], b[5:0] & u8d_pkg::ContMask[5:0]};

   always_comb begin
      remain_in  = remain_ff;
      acc_in     = acc_ff;
      stopped_in = stopped_ff;
      step       = '0;
      step.word.status = u8d_pkg::STATUS_CHAR;
      if (stopped_ff) begin
         if (eos) begin
            stopped_in = 1'b0;
            remain_in  = u8d_pkg::REMAIN_NONE;
            acc_in     = '0;
         end
      end else if (remain_ff == u8d_pkg::REMAIN_NONE) begin
         if (b == '0) begin
            step.has_result  = 1'b1;
            step.word.status = u8d_pkg::STATUS_NUL;
            step.word.last   = 1'b1;
            acc_in           = '0;
            stopped_in       = !eos;
         end else if ((b & u8d_pkg::MaskTop1) == '0) begin
            step.has_result      = 1'b1;
            step.word.code_point = u8d_pkg::CpWidth'(b[6:0]);
            step.word.last       = eos;
            if (eos) begin
               acc_in = '0;
            end
         end else if ((b & u8d_pkg::MaskTop3) == u8d_pkg::Lead2Pat) begin
            acc_in    = u8d_pkg::CpWidth'(b & u8d_pkg::Lead2Mask);
            remain_in = u8d_pkg::REMAIN_ONE;
         end else if ((b & u8d_pkg::MaskTop4) == u8d_pkg::Lead3Pat) begin
            acc_in    = u8d_pkg::CpWidth'(b & u8d_pkg::Lead3Mask);
            remain_in = u8d_pkg::REMAIN_TWO;
         end else if ((b & u8d_pkg::MaskTop5) == u8d_pkg::Lead4Pat) begin
            acc_in    = u8d_pkg::CpWidth'(b & u8d_pkg::Lead4Mask);
            remain_in = u8d_pkg::REMAIN_THREE;
         end else begin
            step.has_result  = 1'b1;
            step.word.status = u8d_pkg::STATUS_INVALID;
            step.word.last   = 1'b1;
            acc_in           = '0;
            stopped_in       = !eos;
         end
         // multi-byte lead with the end flag is cut short
         if (eos && (remain_in != u8d_pkg::REMAIN_NONE)) begin
            remain_in        = u8d_pkg::REMAIN_NONE;
            acc_in           = '0;
            step.has_result  = 1'b1;
            step.word.status = u8d_pkg::STATUS_TRUNC;
            step.word.last   = 1'b1;
         end
      end else begin
         remain_in = u8d_pkg::remain_type'(remain_ff - 2'd1);
         acc_in    = shifted;
         if (remain_in == u8d_pkg::REMAIN_NONE) begin
            step.has_result      = 1'b1;
            step.word.code_point = shifted;
            step.word.last       = eos;
            acc_in               = '0;
         end else if (eos) begin
            remain_in        = u8d_pkg::REMAIN_NONE;
            acc_in           = '0;
            step.has_result  = 1'b1;
            step.word.status = u8d_pkg::STATUS_TRUNC;
            step.word.last   = 1'b1;
         end
      end
   end

   // a word with no result never waits on the output side
   assign take = word_valid && (out_free || !step.has_result);

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff  <= u8d_pkg::REMAIN_NONE;
         acc_ff     <= '0;
         stopped_ff <= 1'b0;
      end else if (take) begin
         remain_ff  <= remain_in;
         acc_ff     <= acc_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

/* hdl/u8d_out_stage.sv */
// ----------------------------------------------------------------------------
// u8d_out_stage
// result register: holds one result word until the receiver takes it
// ----------------------------------------------------------------------------
module u8d_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  u8d_pkg::rsp_word_type load_word,
   output logic                  free,
   output logic                  dn_valid,
   input  logic                  dn_ready,
   output u8d_pkg::rsp_word_type dn_word
);

   logic                  valid_ff, valid_in;
   u8d_pkg::rsp_word_type word_ff, word_in;

   assign free = !valid_ff || dn_ready;

   always_comb begin
      valid_in = valid_ff && !dn_ready;
      word_in  = word_ff;
      if (load) begin
         valid_in = 1'b1;
         word_in  = load_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign dn_valid = valid_ff;
   assign dn_word  = word_ff;

endmodule
